[design/ttb_pkg.sv]
// Package with shared types and constants of the triangle tangent basis block.
`default_nettype none
package ttb_pkg;
   localparam int unsigned CoordWidth = 16;
   localparam int unsigned DeltaWidth = 17;
   localparam int unsigned NumerWidth = 35;
   localparam int unsigned DividendWidth = 56;
   localparam int unsigned QuotWidth = 56;
   localparam int unsigned ResultWidth = 32;
   localparam int unsigned NumDivs = 6;
   localparam int unsigned DivIdxWidth = 3;
   localparam int unsigned FracShift = 20;

   typedef struct packed {
      logic signed [CoordWidth-1:0] pos_x;
      logic signed [CoordWidth-1:0] pos_y;
      logic signed [CoordWidth-1:0] pos_z;
      logic signed [CoordWidth-1:0] tex_u;
      logic signed [CoordWidth-1:0] tex_v;
   } vertex_type;

   typedef struct packed {
      logic signed [ResultWidth-1:0] tangent_x;
      logic signed [ResultWidth-1:0] tangent_y;
      logic signed [ResultWidth-1:0] tangent_z;
      logic signed [ResultWidth-1:0] bitangent_x;
      logic signed [ResultWidth-1:0] bitangent_y;
      logic signed [ResultWidth-1:0] bitangent_z;
      logic                          degenerate;
      logic                          last_of_triangle;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic hold_first;
      logic hold_second;
      logic setup;
      logic div_start;
      logic div_step;
      logic div_store;
      logic [DivIdxWidth-1:0] div_idx;
   } ttb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic degenerate;
      logic div_done;
   } ttb_status_type;
endpackage
`default_nettype wire

[design/ttb_stream_if.sv]
// Valid/ready stream interface carrying one payload.
`default_nettype none
interface ttb_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/ttb_datapath.sv]
// Datapath: held vertices, deltas, numerators and a shared radix-2 divider.
`default_nettype none
module ttb_datapath (
   input  wire logic                    clock,
   input  wire ttb_pkg::vertex_type     vertex,
   input  wire ttb_pkg::ttb_cmd_type    cmd,
   output      ttb_pkg::ttb_status_type status,
   output      ttb_pkg::result_type     result
);
   localparam int unsigned DW = ttb_pkg::DeltaWidth;
   localparam int unsigned NW = ttb_pkg::NumerWidth;
   localparam int unsigned XW = ttb_pkg::DividendWidth;
   localparam int unsigned RW = ttb_pkg::ResultWidth;
   localparam int unsigned StepCountWidth = 6;

   ttb_pkg::vertex_type p1_ff, p2_ff;
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] d1u_ff, d1v_ff, d2u_ff, d2v_ff;
   logic signed [NW-1:0] det_ff;
   logic [XW-1:0] rem_ff, quo_ff;
   logic [NW-1:0] div_mag_ff;
   logic          neg_ff;
   logic [StepCountWidth-1:0] step_ff;
   logic signed [RW-1:0] res_ff [ttb_pkg::NumDivs];
   logic signed [NW-1:0] mul_a_ff, mul_b_ff;
   logic [1:0] numer_phase_ff;

   logic signed [DW-1:0] e1_in [3];
   logic signed [DW-1:0] e2_in [3];
   logic signed [DW-1:0] d1u_in, d1v_in, d2u_in, d2v_in;
   logic [XW:0] trial;
   logic [XW-1:0] rem_sh;
   logic signed [XW:0] sq;
   logic signed [RW-1:0] sat;
   logic [1:0] comp;
   logic       is_tan;

   always_comb begin
      e1_in[0] = DW'(vertex.pos_x) - DW'(p2_ff.pos_x);
      e1_in[1] = DW'(vertex.pos_y) - DW'(p2_ff.pos_y);
      e1_in[2] = DW'(vertex.pos_z) - DW'(p2_ff.pos_z);
      e2_in[0] = DW'(p1_ff.pos_x) - DW'(p2_ff.pos_x);
      e2_in[1] = DW'(p1_ff.pos_y) - DW'(p2_ff.pos_y);
      e2_in[2] = DW'(p1_ff.pos_z) - DW'(p2_ff.pos_z);
      d1u_in = DW'(vertex.tex_u) - DW'(p2_ff.tex_u);
      d1v_in = DW'(vertex.tex_v) - DW'(p2_ff.tex_v);
      d2u_in = DW'(p1_ff.tex_u) - DW'(p2_ff.tex_u);
      d2v_in = DW'(p1_ff.tex_v) - DW'(p2_ff.tex_v);
   end

   // Division index: 0..2 tangent, 3..5 bitangent components.
   assign is_tan = (cmd.div_idx < 3'd3);
   assign comp = is_tan ? cmd.div_idx[1:0] : 2'(cmd.div_idx - 3'd3);

   always_ff @(posedge clock) begin
      if (cmd.hold_first) p1_ff <= vertex;
      if (cmd.hold_second) p2_ff <= vertex;
      if (cmd.setup) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         d1u_ff <= d1u_in;
         d1v_ff <= d1v_in;
         d2u_ff <= d2u_in;
         d2v_ff <= d2v_in;
         det_ff <= NW'(d1u_in * d2v_in) - NW'(d1v_in * d2u_in);
      end
   end

   // Numerator: two products registered, then the difference, over the start cycles.
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         numer_phase_ff <= numer_phase_ff + 2'd1;
         if (numer_phase_ff == 2'd0) begin
            if (is_tan) begin
               mul_a_ff <= NW'(e1_ff[comp] * d2v_ff);
               mul_b_ff <= NW'(e2_ff[comp] * d1v_ff);
            end else begin
               mul_a_ff <= NW'(e2_ff[comp] * d1u_ff);
               mul_b_ff <= NW'(e1_ff[comp] * d2u_ff);
            end
         end else begin
            neg_ff <= (mul_a_ff - mul_b_ff < 0) ^ det_ff[NW-1];
            rem_ff <= '0;
            quo_ff <= XW'((mul_a_ff - mul_b_ff < 0) ? -(mul_a_ff - mul_b_ff)
                                                  : (mul_a_ff - mul_b_ff)) << ttb_pkg::FracShift;
            div_mag_ff <= det_ff[NW-1] ? NW'(-det_ff) : NW'(det_ff);
            step_ff <= '0;
         end
      end else begin
         numer_phase_ff <= 2'd0;
      end
      if (cmd.div_step) begin
         rem_ff <= trial[XW] ? rem_sh : trial[XW-1:0];
         quo_ff <= {quo_ff[XW-2:0], ~trial[XW]};
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.div_store) res_ff[cmd.div_idx] <= sat;
   end

   // Restoring division: one quotient bit per cycle while div_step is asserted.
   assign rem_sh = {rem_ff[XW-2:0], quo_ff[XW-1]};
   assign trial = {1'b0, rem_sh} - {1'b0, XW'(div_mag_ff)};

   always_comb begin
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (sq > $signed((XW+1)'(2147483647))) sat = 32'sh7fffffff;
      else if (sq < -$signed((XW+1)'(64'h80000000))) sat = 32'sh80000000;
      else sat = RW'(sq);
   end

   assign status.degenerate = (det_ff == '0);
   assign status.div_done = (step_ff == StepCountWidth'(XW - 1)) && cmd.div_step;

   always_comb begin
      result.tangent_x = status.degenerate ? '0 : res_ff[0];
      result.tangent_y = status.degenerate ? '0 : res_ff[1];
      result.tangent_z = status.degenerate ? '0 : res_ff[2];
      result.bitangent_x = status.degenerate ? '0 : res_ff[3];
      result.bitangent_y = status.degenerate ? '0 : res_ff[4];
      result.bitangent_z = status.degenerate ? '0 : res_ff[5];
      result.degenerate = status.degenerate;
      result.last_of_triangle = 1'b0;
   end
endmodule
`default_nettype wire

[design/ttb_control.sv]
// Controller: vertex sequencing, division schedule and the three result transactions.
`default_nettype none
module ttb_control (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic                    rsp_last,
   input  wire ttb_pkg::ttb_status_type status,
   output      ttb_pkg::ttb_cmd_type    cmd
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_STORE = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] start_ff, start_in;
   logic [ttb_pkg::DivIdxWidth-1:0] idx_ff, idx_in;
   logic [1:0] rep_ff, rep_in;
   logic take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_last = (rep_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      idx_in = idx_ff;
      rep_in = rep_ff;
      cmd = '0;
      cmd.div_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.hold_first = (phase_ff == 2'd0);
               cmd.hold_second = (phase_ff == 2'd1);
               cmd.setup = (phase_ff == 2'd2);
               if (phase_ff == 2'd2) begin
                  phase_in = 2'd0;
                  idx_in = '0;
                  start_in = '0;
                  state_in = ST_START;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         ST_START: begin
            if (status.degenerate) begin
               rep_in = '0;
               state_in = ST_OUT;
            end else begin
               cmd.div_start = 1'b1;
               start_in = start_ff + 2'd1;
               if (start_ff == 2'd1) state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.div_store = 1'b1;
            start_in = '0;
            if (idx_ff == ttb_pkg::DivIdxWidth'(ttb_pkg::NumDivs - 1)) begin
               rep_in = '0;
               state_in = ST_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_START;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rep_in = rep_ff + 2'd1;
               if (rep_ff == 2'd2) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         start_ff <= '0;
         idx_ff <= '0;
         rep_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         idx_ff <= idx_in;
         rep_ff <= rep_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_phase: assert property (@(posedge clock) disable iff (reset) phase_ff != 2'd3)
      else $error("vertex phase out of range");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> state_ff == ST_IDLE)
      else $error("burst did not end after last result");
endmodule
`default_nettype wire

[design/triangle_tangent_basis.sv]
// Top level of the per-triangle tangent and bitangent block.
//  channel | dir | payload            | handshake
//  req     | in  | one vertex         | req_valid / req_ready
//  rsp     | out | tangent, bitangent | rsp_valid / rsp_ready, three per triangle
// First and second vertex of a triangle are only held in registers.
// The third vertex runs six divisions, each a numerator setup, quotient steps and a store
// on the single bit-per-cycle divider; then three results.
// A zero determinant skips the divisions. Reset is synchronous and clears control only.
// Input is not taken while the divisions or result transactions are pending.
`default_nettype none
module triangle_tangent_basis (
   input wire logic clock,
   input wire logic reset,
   ttb_stream_if.sink   req,
   ttb_stream_if.source rsp
);
   ttb_pkg::ttb_cmd_type    cmd;
   ttb_pkg::ttb_status_type status;
   ttb_pkg::result_type     result;
   logic last;

   ttb_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(last),
      .status(status), .cmd(cmd)
   );

   ttb_datapath u_datapath (
      .clock(clock), .vertex(req.payload), .cmd(cmd),
      .status(status), .result(result)
   );

   always_comb begin
      rsp.payload = result;
      rsp.payload.last_of_triangle = last;
   end
endmodule
`default_nettype wire
